// File: src/vsdts_pkg.sv
// Shared types and codes for the vector store with dot-product threshold scan.
// Used by vsdts_cell, vsdts_dot and vector_store_dot_threshold_scan.
`timescale 1ns / 1ps
`default_nettype none

package vsdts_pkg;

  // One stored vector, x in the lowest bits
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } vec_t;

  // Control token that travels with an entry through the dot pipeline
  typedef struct packed {
    logic       vld;
    logic       done;
    logic [4:0] id;
  } tok_t;

  // Input commands
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_SCAN   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_APPENDED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_DONE     = 2'd3;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

  localparam logic [15:0] THRESHOLD_RST = 16'd13926;
  localparam logic [5:0]  CAPACITY_RST  = 6'd32;

endpackage

`default_nettype wire

// File: src/vsdts_cell.sv
// One storage cell of the entry chain: holds a single vector.
// Loads on append, or takes its neighbor's vector while the chain rotates.
`timescale 1ns / 1ps
`default_nettype none

module vsdts_cell (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire vsdts_pkg::vec_t wr_data,
  input  wire logic           shift_en,
  input  wire vsdts_pkg::vec_t shift_in,
  output vsdts_pkg::vec_t     data
);
  import vsdts_pkg::*;

  vec_t data_r;

  // Append write wins; rotation only runs during a scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_r <= wr_data;
    end else if (shift_en) begin
      data_r <= shift_in;
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: src/vsdts_dot.sv
// Two-stage dot product and threshold compare for the scan path.
// Stage 1 registers three 16x16 products, stage 2 the sum and the compare.
`timescale 1ns / 1ps
`default_nettype none

module vsdts_dot (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire vsdts_pkg::tok_t     tok_in,
  input  wire vsdts_pkg::vec_t     qry,
  input  wire vsdts_pkg::vec_t     ent,
  input  wire logic signed [15:0]  thr,
  output vsdts_pkg::tok_t          tok_out,
  output logic signed [32:0]       dot_out,
  output logic                     hit,
  output vsdts_pkg::vec_t          ent_out
);
  import vsdts_pkg::*;

  tok_t               tok1_r, tok2_r;
  vec_t               ent1_r, ent2_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [31:0] px_nxt, py_nxt, pz_nxt;
  logic signed [32:0] sum_nxt, dot2_r, thr_ext;
  logic               hit2_r;

  // Products
  assign px_nxt = qry.x * ent.x;
  assign py_nxt = qry.y * ent.y;
  assign pz_nxt = qry.z * ent.z;

  // Sum and threshold scaled by 2^14
  assign sum_nxt = 33'(px_r) + 33'(py_r) + 33'(pz_r);
  assign thr_ext = $signed({{3{thr[15]}}, thr, 14'd0});

  // Token registers (valid, done and id)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r <= '0;
      tok2_r <= '0;
    end else if (adv) begin
      tok1_r <= tok_in;
      tok2_r <= tok1_r;
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      ent1_r <= ent;
      dot2_r <= sum_nxt;
      hit2_r <= sum_nxt > thr_ext;
      ent2_r <= ent1_r;
    end
  end

  assign tok_out = tok2_r;
  assign dot_out = dot2_r;
  assign hit     = hit2_r;
  assign ent_out = ent2_r;

endmodule

`default_nettype wire

// File: src/vector_store_dot_threshold_scan.sv
// Append-only vector store with a rotating chain of cells and a dot-product scan.
// Append: accepted when idle; the result is registered in the append state once the
// output register is free.
// Scan: the chain rotates once, one entry a cycle (while the output is not stalled) into
// a two-stage dot unit; a done token follows the last entry and its result ends the
// scan. A full output stalls the whole scan. Reset clears state, count, scan index,
// output valid and config registers; stored vectors and payload are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module vector_store_dot_threshold_scan #(
  parameter int DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // vec_x[15:0], vec_y[31:16], vec_z[47:32]
  input  wire logic        in_tuser,  // command[0]
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata, // entry_id[4:0], score[37:5], match_x[53:38],
                                      // match_y[69:54], match_z[85:70], zero[87:86]
  output logic [1:0]       out_tuser, // status[1:0]
  output logic             out_tlast,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import vsdts_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = $clog2(DEPTH + 2);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_APPEND = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  vec_t                qry_r;
  logic signed [15:0]  thr_r;
  logic [5:0]          cap_r;
  logic [5:0]          limit;
  logic                full;
  logic                adv;
  logic                wr_en, shift_en;
  vec_t                cells [DEPTH];
  tok_t                tok_in, tok_out;
  logic signed [32:0]  dot;
  logic                hit;
  vec_t                ent_out;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [4:0]          out_id_r, out_id_nxt;
  logic signed [32:0]  out_score_r, out_score_nxt;
  vec_t                out_vec_r, out_vec_nxt;
  logic                out_last_r, out_last_nxt;

  // Output register frees up when empty or being taken
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RST;
      cap_r <= CAPACITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_data;
        REG_CAPACITY:  cap_r <= cfg_data[5:0];
      endcase
    end
  end

  // Store full check against min(capacity, DEPTH)
  assign limit = (cap_r > 6'(DEPTH)) ? 6'(DEPTH) : cap_r;
  assign full  = 6'(count_r) >= limit;

  assign wr_en    = (state_r == S_APPEND) && adv && !full;
  assign shift_en = (state_r == S_SCAN) && adv && (k_r < KW'(DEPTH));

  // Chain of cells, rotating toward cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    vsdts_cell u_cell (
      .clk      (clk),
      .wr_en    (wr_en && (count_r[IW-1:0] == IW'(i))),
      .wr_data  (qry_r),
      .shift_en (shift_en),
      .shift_in (cells[(i + 1) % DEPTH]),
      .data     (cells[i])
    );
  end

  // Token for the entry now at the head, or the done marker after the last rotation
  always_comb begin
    tok_in      = '0;
    tok_in.id   = 5'(k_r);
    tok_in.done = (k_r == KW'(DEPTH));
    if ((state_r == S_SCAN) && adv) begin
      if (k_r < KW'(DEPTH)) begin
        tok_in.vld = k_r < KW'(count_r);
      end else begin
        tok_in.vld = (k_r == KW'(DEPTH));
      end
    end
  end

  vsdts_dot u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .tok_in  (tok_in),
    .qry     (qry_r),
    .ent     (cells[0]),
    .thr     (thr_r),
    .tok_out (tok_out),
    .dot_out (dot),
    .hit     (hit),
    .ent_out (ent_out)
  );

  // Sequencer and output register loading
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_score_nxt  = out_score_r;
    out_vec_nxt    = out_vec_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          k_nxt     = '0;
          state_nxt = (in_tuser == CMD_SCAN) ? S_SCAN : S_APPEND;
        end
      end
      S_APPEND: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_score_nxt = '0;
          out_vec_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (full) begin
            out_status_nxt = ST_FULL;
            out_id_nxt     = '0;
          end else begin
            out_status_nxt = ST_APPENDED;
            out_id_nxt     = 5'(count_r);
            count_nxt      = count_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (adv) begin
          if (k_r <= KW'(DEPTH)) begin
            k_nxt = k_r + 1'b1;
          end
          if (tok_out.vld && tok_out.done) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DONE;
            out_id_nxt     = '0;
            out_score_nxt  = '0;
            out_vec_nxt    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else if (tok_out.vld && hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MATCH;
            out_id_nxt     = tok_out.id;
            out_score_nxt  = dot;
            out_vec_nxt    = ent_out;
            out_last_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      qry_r <= in_tdata;
    end
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_score_r  <= out_score_nxt;
    out_vec_r    <= out_vec_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_vec_r.z, out_vec_r.y, out_vec_r.x, out_score_r, out_id_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) && $past(rst_n) |-> count_r == CW'($past(count_r) + 1'b1))
    else $error("entry count moved by other than one");

  a_scan_no_append: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && $past(state_r == S_SCAN) |-> $stable(count_r))
    else $error("entry count changed during scan");

  a_match_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_MATCH) |->
      (out_score_r > $signed({{3{thr_r[15]}}, thr_r, 14'd0})) && !out_last_r)
    else $error("match result not above threshold");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (state_r == S_SCAN) && tok_out.vld && tok_out.done |=> state_r == S_IDLE)
    else $error("scan did not end after done result");

endmodule

`default_nettype wire
